// ----- hdl/frt_pkg.sv -----
package frt_pkg;

    // ethernet and transport codes
    localparam logic [15:0] ETHER_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_TCP  = 8'd6;
    localparam logic [7:0]  PROTO_UDP  = 8'd17;

    // per-field refresh modes
    localparam logic [1:0] MODE_OFF   = 2'd0;
    localparam logic [1:0] MODE_INCR  = 2'd1;
    localparam logic [1:0] MODE_FIXED = 2'd2;

    // flow direction codes
    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_FWD  = 2'd1;
    localparam logic [1:0] DIR_REV  = 2'd2;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_MATCH_MODES = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_LIMITS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DST_LIMITS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PORT_LIMITS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ADDR_STEPS  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FIXED_ADDRS = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PORT_STEPS  = 3'd6;

    localparam logic [31:0] MATCH_MODES_RESET = 32'h0001_0000;

    // raw configuration registers
    typedef struct packed {
        logic [31:0] match_modes;
        logic [63:0] src_addr_limits;
        logic [63:0] dst_addr_limits;
        logic [63:0] port_limits;
        logic [63:0] addr_steps;
        logic [63:0] fixed_addrs;
        logic [63:0] port_steps_fixed;
    } cfg_t;

    // address and port tuple
    typedef struct packed {
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] sport;
        logic [15:0] dport;
    } tuple_t;

    // input item as packed on the stream, first field lowest
    typedef struct packed {
        logic [15:0] dport;
        logic [15:0] sport;
        logic [31:0] dst_addr;
        logic [31:0] src_addr;
        logic [7:0]  ip_proto;
        logic [15:0] ether_kind;
    } in_item_t;

    // result data, first field lowest
    typedef struct packed {
        logic [15:0] out_dport;
        logic [15:0] out_sport;
        logic [31:0] out_dst_addr;
        logic [31:0] out_src_addr;
    } res_data_t;

    // result flags, first field lowest
    typedef struct packed {
        logic       not_ipv4;
        logic [1:0] flow_dir;
    } res_user_t;

    // flow tracking state
    typedef struct packed {
        logic [15:0] period_count;
        logic        target_taken;
        logic [31:0] target_src;
        logic [31:0] target_dst;
        tuple_t      cur;
    } flow_state_t;

endpackage

// ----- hdl/frt_cfg_regs.sv -----
module frt_cfg_regs
    import frt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // register writes, unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.match_modes      <= MATCH_MODES_RESET;
            cfg_reg.src_addr_limits  <= '0;
            cfg_reg.dst_addr_limits  <= '0;
            cfg_reg.port_limits      <= '0;
            cfg_reg.addr_steps       <= '0;
            cfg_reg.fixed_addrs      <= '0;
            cfg_reg.port_steps_fixed <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_MATCH_MODES: cfg_reg.match_modes      <= cfg_data[31:0];
                REG_SRC_LIMITS:  cfg_reg.src_addr_limits  <= cfg_data;
                REG_DST_LIMITS:  cfg_reg.dst_addr_limits  <= cfg_data;
                REG_PORT_LIMITS: cfg_reg.port_limits      <= cfg_data;
                REG_ADDR_STEPS:  cfg_reg.addr_steps       <= cfg_data;
                REG_FIXED_ADDRS: cfg_reg.fixed_addrs      <= cfg_data;
                REG_PORT_STEPS:  cfg_reg.port_steps_fixed <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

endmodule

// ----- hdl/frt_refresh.sv -----
module frt_refresh
    import frt_pkg::*;
(
    input  cfg_t   cfg,
    input  tuple_t cur,
    output tuple_t fresh
);

    // increment with clamp, or load, or keep
    function automatic logic [31:0] next_addr(input logic [1:0] mode, input logic [31:0] val,
                                              input logic [31:0] step, input logic [31:0] lo,
                                              input logic [31:0] hi, input logic [31:0] fixed);
        logic [31:0] sum;
        logic [31:0] res;
        sum = val + ((step == 32'd0) ? 32'd1 : step);
        res = val;
        if (mode == MODE_INCR)
        begin
            if (sum < lo)
                res = lo;
            else if (sum > hi)
                res = hi;
            else
                res = sum;
        end
        else if (mode == MODE_FIXED)
            res = fixed;
        return res;
    endfunction

    // increment with wrap to minimum, or load, or keep
    function automatic logic [15:0] next_port(input logic [1:0] mode, input logic [15:0] val,
                                              input logic [15:0] step, input logic [15:0] lo,
                                              input logic [15:0] hi, input logic [15:0] fixed);
        logic [15:0] sum;
        logic [15:0] res;
        sum = val + ((step == 16'd0) ? 16'd1 : step);
        res = val;
        if (mode == MODE_INCR)
            res = (sum < lo || sum > hi) ? lo : sum;
        else if (mode == MODE_FIXED)
            res = fixed;
        return res;
    endfunction

    assign fresh.src_addr = next_addr(cfg.match_modes[1:0], cur.src_addr,
                                      cfg.addr_steps[63:32], cfg.src_addr_limits[63:32],
                                      cfg.src_addr_limits[31:0], cfg.fixed_addrs[63:32]);
    assign fresh.dst_addr = next_addr(cfg.match_modes[3:2], cur.dst_addr,
                                      cfg.addr_steps[31:0], cfg.dst_addr_limits[63:32],
                                      cfg.dst_addr_limits[31:0], cfg.fixed_addrs[31:0]);
    assign fresh.sport    = next_port(cfg.match_modes[5:4], cur.sport,
                                      cfg.port_steps_fixed[63:48], cfg.port_limits[63:48],
                                      cfg.port_limits[47:32], cfg.port_steps_fixed[31:16]);
    assign fresh.dport    = next_port(cfg.match_modes[7:6], cur.dport,
                                      cfg.port_steps_fixed[47:32], cfg.port_limits[31:16],
                                      cfg.port_limits[15:0], cfg.port_steps_fixed[15:0]);

endmodule

// ----- hdl/frt_core.sv -----
module frt_core
    import frt_pkg::*;
(
    input  cfg_t        cfg,
    input  in_item_t    item,
    input  flow_state_t state,
    output flow_state_t state_next,
    output res_data_t   res_data,
    output res_user_t   res_user
);

    logic        is_ipv4;
    logic        is_match;
    logic        at_refresh;
    logic        take_target;
    logic        taken_now;
    logic [31:0] tgt_src;
    logic [31:0] tgt_dst;
    logic        is_fwd;
    logic        is_rev;
    logic        is_l4;
    logic [15:0] period;
    logic [15:0] count_inc;
    logic [1:0]  dir;
    tuple_t      fresh;
    tuple_t      cur_now;
    tuple_t      repl;

    frt_refresh u_refresh
    (
        .cfg   (cfg),
        .cur   (state.cur),
        .fresh (fresh)
    );

    // packet classification
    assign is_ipv4     = (item.ether_kind == ETHER_IPV4);
    assign is_match    = is_ipv4 && (item.ip_proto == cfg.match_modes[15:8]);
    assign at_refresh  = is_match && (state.period_count == 16'd0);
    assign take_target = at_refresh && !state.target_taken;
    assign taken_now   = state.target_taken || take_target;
    assign tgt_src     = take_target ? item.src_addr : state.target_src;
    assign tgt_dst     = take_target ? item.dst_addr : state.target_dst;
    assign cur_now     = at_refresh ? fresh : state.cur;
    assign is_l4       = (item.ip_proto == PROTO_TCP) || (item.ip_proto == PROTO_UDP);

    // flow direction, forward wins on a symmetric target
    assign is_fwd = is_match && taken_now
                    && (item.src_addr == tgt_src) && (item.dst_addr == tgt_dst);
    assign is_rev = is_match && taken_now
                    && (item.src_addr == tgt_dst) && (item.dst_addr == tgt_src);

    always_comb
    begin
        priority if (is_fwd)
            dir = DIR_FWD;
        else if (is_rev)
            dir = DIR_REV;
        else
            dir = DIR_NONE;
    end

    // replacement tuple seen from the packet's side
    always_comb
    begin
        repl = cur_now;
        if (dir == DIR_REV)
        begin
            repl.src_addr = cur_now.dst_addr;
            repl.dst_addr = cur_now.src_addr;
            repl.sport    = cur_now.dport;
            repl.dport    = cur_now.sport;
        end
    end

    // rewrite, zero replacements are skipped
    always_comb
    begin
        res_data.out_src_addr = item.src_addr;
        res_data.out_dst_addr = item.dst_addr;
        res_data.out_sport    = item.sport;
        res_data.out_dport    = item.dport;
        if (dir != DIR_NONE)
        begin
            if (repl.src_addr != 32'd0)
                res_data.out_src_addr = repl.src_addr;
            if (repl.dst_addr != 32'd0)
                res_data.out_dst_addr = repl.dst_addr;
            if (is_l4 && repl.sport != 16'd0)
                res_data.out_sport = repl.sport;
            if (is_l4 && repl.dport != 16'd0)
                res_data.out_dport = repl.dport;
        end
    end

    assign res_user.flow_dir = dir;
    assign res_user.not_ipv4 = !is_ipv4;

    // packet counter over all packets
    assign period    = cfg.match_modes[31:16];
    assign count_inc = state.period_count + 16'd1;

    always_comb
    begin
        state_next              = state;
        state_next.period_count = (period != 16'd0 && count_inc >= period) ? 16'd0 : count_inc;
        state_next.target_taken = taken_now;
        state_next.target_src   = tgt_src;
        state_next.target_dst   = tgt_dst;
        state_next.cur          = cur_now;
    end

endmodule

// ----- hdl/flow_tuple_rewriter_top.sv -----
// flow tuple rewriter: rewrites addresses and ports of one tracked flow
// each header passes through the input register and then the result register
// throughput: one header per cycle while the result register is not stalled;
// the state update is combinational between input and result register
// reset: asynchronous active low, configuration to its reset values, flow state
// and both stage valid flags cleared
module flow_tuple_rewriter_top
    import frt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // ether_kind, ip_proto, src_addr, dst_addr, sport, dport
    input  logic [119:0]         s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // out_src_addr, out_dst_addr, out_sport, out_dport
    output logic [95:0]          m_axis_tdata,
    // flow_dir, not_ipv4
    output logic [2:0]           m_axis_tuser
);

    cfg_t        cfg;
    logic        in_valid_reg;
    in_item_t    in_item_reg;
    logic        out_valid_reg;
    res_data_t   out_data_reg;
    res_user_t   out_user_reg;
    flow_state_t state_reg;
    flow_state_t state_next;
    res_data_t   res_data;
    res_user_t   res_user;
    logic        advance;

    frt_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    frt_core u_core
    (
        .cfg        (cfg),
        .item       (in_item_reg),
        .state      (state_reg),
        .state_next (state_next),
        .res_data   (res_data),
        .res_user   (res_user)
    );

    // handshake: the input stage moves on when the result register is free
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
            in_item_reg <= s_axis_tdata;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= res_data;
            out_user_reg <= res_user;
        end
    end

    // flow state, updated once per header
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (advance)
            state_reg <= state_next;
    end

    // checks
    a_dir_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser[1:0] == DIR_NONE || m_axis_tuser[1:0] == DIR_FWD
                           || m_axis_tuser[1:0] == DIR_REV))
        else $error("flow direction code out of range");

    a_nonip_no_dir: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[2]) |-> (m_axis_tuser[1:0] == DIR_NONE))
        else $error("non-IPv4 packet marked as part of the flow");

    a_dir_needs_target: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[1:0] != DIR_NONE) |-> state_reg.target_taken)
        else $error("flow match without a captured target");

    a_target_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.target_taken |=> state_reg.target_taken)
        else $error("target flow lost after capture");

endmodule
